// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("upd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("upd assertion failed");

`endif

// ----- rtl/core/upd_pkg.sv -----
// Shared types and constants of the percent decoder.
// No dependencies.
package upd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_UNTERM   = 2'd1,
    STATUS_BAD_HEX  = 2'd2,
    STATUS_BAD_UTF8 = 2'd3
  } status_e;

  // Word passed from the escape front end to the UTF-8 back end.
  typedef struct packed {
    logic [7:0] data;     // decoded byte, valid when have is set
    logic       have;
    logic       last;
    status_e    esc_status; // escape error of the string, on the last word
  } mid_item_t;

endpackage

// ----- rtl/core/upd_front.sv -----
// Front end: percent-escape parsing and hex decoding.
// Depends on upd_pkg.
module upd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  output logic              wr_o,
  output upd_pkg::mid_item_t item_o
);

  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_HEX1 = 3'b010,
    ESC_HEX2 = 3'b100
  } esc_state_e;

  localparam logic [7:0] PercentChar = 8'h25;

  esc_state_e        state_q, state_d;
  logic [3:0]        hi_q, hi_d;
  upd_pkg::status_e  err_q, err_d;

  logic              hex_ok;
  logic [3:0]        hex_val;
  logic              have;
  logic [7:0]        dec;
  upd_pkg::status_e  esc;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    priority if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_val = 4'(in_byte_i - 8'h30);
    end else if (in_byte_i >= 8'h41 && in_byte_i <= 8'h46) begin
      hex_val = 4'(in_byte_i - 8'h37);
    end else if (in_byte_i >= 8'h61 && in_byte_i <= 8'h66) begin
      hex_val = 4'(in_byte_i - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    hi_d    = hi_q;
    err_d   = err_q;
    have    = 1'b0;
    dec     = in_byte_i;
    esc     = upd_pkg::STATUS_OK;
    if (err_q == upd_pkg::STATUS_OK) begin
      unique case (state_q)
        ESC_IDLE: begin
          if (in_byte_i == PercentChar) begin
            if (in_last_i) esc = upd_pkg::STATUS_UNTERM;
            else           state_d = ESC_HEX1;
          end else begin
            have = 1'b1;
          end
        end
        ESC_HEX1: begin
          if (in_last_i) begin
            esc = upd_pkg::STATUS_UNTERM;
          end else if (!hex_ok) begin
            esc = upd_pkg::STATUS_BAD_HEX;
          end else begin
            hi_d    = hex_val;
            state_d = ESC_HEX2;
          end
        end
        ESC_HEX2: begin
          if (!hex_ok) begin
            esc = upd_pkg::STATUS_BAD_HEX;
          end else begin
            have    = 1'b1;
            dec     = {hi_q, hex_val};
            state_d = ESC_IDLE;
          end
        end
        default: state_d = ESC_IDLE;
      endcase
      err_d = esc;
    end
    // string ends: everything back to idle
    if (in_last_i) begin
      state_d = ESC_IDLE;
      hi_d    = 4'd0;
      err_d   = upd_pkg::STATUS_OK;
    end
  end

  assign wr_o              = fire_i && (have || in_last_i);
  assign item_o.data       = dec;
  assign item_o.have       = have;
  assign item_o.last       = in_last_i;
  assign item_o.esc_status = (err_q != upd_pkg::STATUS_OK) ? err_q : esc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ESC_IDLE;
      hi_q    <= 4'd0;
      err_q   <= upd_pkg::STATUS_OK;
    end else if (fire_i) begin
      state_q <= state_d;
      hi_q    <= hi_d;
      err_q   <= err_d;
    end
  end

endmodule

// ----- rtl/core/upd_queue.sv -----
// Short queue between front and back end, flip-flop storage.
// Depends on upd_pkg.
module upd_queue #(
  parameter int unsigned Depth = upd_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  upd_pkg::mid_item_t wdata_i,
  input  logic               rd_i,
  output upd_pkg::mid_item_t rdata_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  upd_pkg::mid_item_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd)      cnt_d = cnt_q + 1'b1;
    else if (do_rd && !do_wr) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

// ----- rtl/core/upd_back.sv -----
// Back end: UTF-8 structure check, status merge and result register.
// Depends on upd_pkg.
module upd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               avail_i,
  input  upd_pkg::mid_item_t item_i,
  output logic               take_o,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_byte_o,
  output logic               out_byte_valid_o,
  output logic               out_last_o,
  output logic [1:0]         status_o
);

  // range allowed for the next continuation byte
  typedef enum logic [2:0] {
    LIM_ANY   = 3'd0,
    LIM_A0_BF = 3'd1,
    LIM_80_9F = 3'd2,
    LIM_90_BF = 3'd3,
    LIM_80_8F = 3'd4
  } limit_e;

  logic [1:0]       pend_q, pend_d;
  limit_e           lim_q, lim_d;
  logic             uerr_q, uerr_d;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_bv_q, out_last_q;
  upd_pkg::status_e out_status_q;

  logic             emit;
  logic [7:0]       lo, hi, b;
  upd_pkg::status_e fin_status;

  assign take_o = avail_i && (!out_valid_q || pop);
  assign b      = item_i.data;

  always_comb begin
    pend_d     = pend_q;
    lim_d      = lim_q;
    uerr_d     = uerr_q;
    emit       = 1'b0;
    fin_status = upd_pkg::STATUS_OK;
    lo         = 8'h80;
    hi         = 8'hBF;
    unique case (lim_q)
      LIM_A0_BF: lo = 8'hA0;
      LIM_80_9F: hi = 8'h9F;
      LIM_90_BF: lo = 8'h90;
      LIM_80_8F: hi = 8'h8F;
      default: ;
    endcase
    if (take_o && item_i.have && !uerr_q) begin
      if (pend_q == 2'd0) begin
        emit = 1'b1;
        priority if (b < 8'h80) begin
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          pend_d = 2'd1; lim_d = LIM_ANY;
        end else if (b == 8'hE0) begin
          pend_d = 2'd2; lim_d = LIM_A0_BF;
        end else if (b == 8'hED) begin
          pend_d = 2'd2; lim_d = LIM_80_9F;
        end else if (b >= 8'hE1 && b <= 8'hEF) begin
          pend_d = 2'd2; lim_d = LIM_ANY;
        end else if (b == 8'hF0) begin
          pend_d = 2'd3; lim_d = LIM_90_BF;
        end else if (b >= 8'hF1 && b <= 8'hF3) begin
          pend_d = 2'd3; lim_d = LIM_ANY;
        end else if (b == 8'hF4) begin
          pend_d = 2'd3; lim_d = LIM_80_8F;
        end else begin
          emit   = 1'b0;
          uerr_d = 1'b1;
        end
      end else if (b < lo || b > hi) begin
        uerr_d = 1'b1;
      end else begin
        emit   = 1'b1;
        lim_d  = LIM_ANY;
        pend_d = pend_q - 2'd1;
      end
    end
    // escape errors win; an open sequence at the end is a UTF-8 error
    if (item_i.esc_status != upd_pkg::STATUS_OK) begin
      fin_status = item_i.esc_status;
    end else if (uerr_d || pend_d != 2'd0) begin
      fin_status = upd_pkg::STATUS_BAD_UTF8;
    end
    if (take_o && item_i.last) begin
      pend_d = 2'd0;
      lim_d  = LIM_ANY;
      uerr_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 2'd0;
      lim_q       <= LIM_ANY;
      uerr_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      lim_q  <= lim_d;
      uerr_q <= uerr_d;
      if (take_o && (emit || item_i.last)) begin
        out_valid_q <= 1'b1;
      end else if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && (emit || item_i.last)) begin
      out_byte_q   <= emit ? b : 8'd0;
      out_bv_q     <= emit;
      out_last_q   <= item_i.last;
      out_status_q <= item_i.last ? fin_status : upd_pkg::STATUS_OK;
    end
  end

  assign empty            = !out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign out_byte_valid_o = out_bv_q;
  assign out_last_o       = out_last_q;
  assign status_o         = out_status_q;

endmodule

// ----- rtl/core/uri_percent_decoder_unit.sv -----
// Percent decoder with UTF-8 checking: escape front end, word queue, back end.
// Depends on upd_pkg, upd_front, upd_queue, upd_back.
//
// Input side is a queue write port: a word (in_byte_i, in_last_i) is taken at
// a clock edge with push high and full low. Result side is a queue read port:
// while empty is low the oldest result sits on out_*_o / status_o and is taken
// at an edge with pop high. One byte per cycle is accepted sustained while
// pop keeps up; the stages are the escape parse and the UTF-8 check. A
// decoded byte passes the word queue and then the result register on its
// way to the result port.
// Bytes inside an escape and bytes after the first error give no result; the
// word marked last always gives one result with out_last_o set and the status
// of the whole string (0 ok, 1 unterminated escape, 2 bad hex, 3 bad UTF-8).
// When pop stays low the result register holds, the queue between front and
// back fills (QueueDepth words), then full rises and input stalls.
// Reset clears all parse state and empties queue and result register; the
// block is ready for a new string once reset is released.
module uri_percent_decoder_unit #(
  parameter int unsigned QueueDepth = upd_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       out_byte_valid_o,
  output logic       out_last_o,
  output logic [1:0] status_o
);

  upd_pkg::mid_item_t wr_item, rd_item;
  logic               wr, q_empty, take, fire;

  assign fire = push && !full;

  upd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .wr_o      (wr),
    .item_o    (wr_item)
  );

  upd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .wdata_i (wr_item),
    .rd_i    (take),
    .rdata_o (rd_item),
    .full_o  (full),
    .empty_o (q_empty)
  );

  upd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .avail_i          (!q_empty),
    .item_i           (rd_item),
    .take_o           (take),
    .empty            (empty),
    .pop              (pop),
    .out_byte_o       (out_byte_o),
    .out_byte_valid_o (out_byte_valid_o),
    .out_last_o       (out_last_o),
    .status_o         (status_o)
  );

endmodule

// ----- rtl/core/upd_checker.sv -----
// Port-level checks of the percent decoder, bound to the top level.
// Depends on assert_macros.svh, upd_pkg, uri_percent_decoder_unit.
`include "assert_macros.svh"

module upd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       out_byte_valid_o,
  input logic       out_last_o,
  input logic [1:0] status_o
);

  // status only rides on the closing word
  `UPD_ASSERT_IMP(a_status_on_last, clk_i, rst_ni, !empty && !out_last_o, status_o == upd_pkg::STATUS_OK)

  // a word without a byte reads zero data
  `UPD_ASSERT_IMP(a_byte_zero, clk_i, rst_ni, !empty && !out_byte_valid_o, out_byte_o == 8'd0)

  // every word carries a byte or closes the string
  `UPD_ASSERT_IMP(a_no_empty_word, clk_i, rst_ni, !empty, out_byte_valid_o || out_last_o)

  // a stalled result holds
  `UPD_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_byte_o) && $stable(status_o))

endmodule

bind uri_percent_decoder_unit upd_checker u_upd_checker (.*);

// ----- sim/tb.sv -----
// Testbench of uri_percent_decoder_unit: directed strings, then random strings,
// checked against a decode model kept in the bench. Depends on upd_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] PERCENT = 8'h25;
  localparam int WORD_TARGET = 950;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {ESC_IDLE, ESC_HI, ESC_LO} esc_e;
  // Allowed range of the next continuation byte.
  typedef enum logic [2:0] {LIM_ANY, LIM_A0, LIM_9F, LIM_90, LIM_8F} lim_e;

  typedef struct packed {
    logic [7:0]       data;
    logic             valid;
    logic             last;
    upd_pkg::status_e stat;
  } res_t;

  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             typed;  // expectation below is used instead of the model
    logic             gives;
    logic [7:0]       ebyte;
    logic             evalid;
    upd_pkg::status_e estat;
  } row_t;

  localparam row_t DIR_ROWS [23] = '{
    '{8'h41, 1'b0, 1'b1, 1'b1, 8'h41, 1'b1, upd_pkg::STATUS_OK},
    '{8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1, upd_pkg::STATUS_OK},
    '{8'h25, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, upd_pkg::STATUS_OK},
    '{8'h37, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, upd_pkg::STATUS_OK},
    '{8'h65, 1'b0, 1'b1, 1'b1, 8'h7E, 1'b1, upd_pkg::STATUS_OK},
    '{8'h7F, 1'b1, 1'b1, 1'b1, 8'h7F, 1'b1, upd_pkg::STATUS_OK},
    // escape cut by end of string
    '{8'h25, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, upd_pkg::STATUS_UNTERM},
    '{8'h25, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, upd_pkg::STATUS_OK},
    '{8'h41, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, upd_pkg::STATUS_UNTERM},
    // bad first digit, then silence until the last word
    '{8'h25, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, upd_pkg::STATUS_OK},
    '{8'h47, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, upd_pkg::STATUS_OK},
    '{8'h30, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, upd_pkg::STATUS_BAD_HEX},
    // %C3%a9: two-byte sequence, second byte rides on the last word
    '{8'h25, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, upd_pkg::STATUS_OK},
    '{8'h43, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, upd_pkg::STATUS_OK},
    '{8'h33, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, upd_pkg::STATUS_OK},
    '{8'h25, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, upd_pkg::STATUS_OK},
    '{8'h61, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, upd_pkg::STATUS_OK},
    '{8'h39, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, upd_pkg::STATUS_OK},
    '{8'hFF, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, upd_pkg::STATUS_BAD_UTF8},
    // open multi-byte sequence at end of string
    '{8'hE2, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, upd_pkg::STATUS_OK},
    // bad second digit on the last word
    '{8'h25, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, upd_pkg::STATUS_OK},
    '{8'h31, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, upd_pkg::STATUS_OK},
    '{8'h78, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, upd_pkg::STATUS_BAD_HEX}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_byte_valid_o;
  logic       out_last_o;
  logic [1:0] status_o;

  uri_percent_decoder_unit DUT (
    .clk_i, .rst_ni, .push, .full, .in_byte_i, .in_last_i,
    .empty, .pop, .out_byte_o, .out_byte_valid_o, .out_last_o, .status_o
  );

  // Decode model state.
  esc_e             esc_ph = ESC_IDLE;
  logic [3:0]       hi_nib = 4'h0;
  logic [1:0]       u_pend = 2'd0;
  lim_e             u_lim = LIM_ANY;
  upd_pkg::status_e err_st = upd_pkg::STATUS_OK;

  res_t       pending_results[$];
  logic [7:0] word_q[$];
  int         mismatches = 0;
  int         sent_words = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         quiet_cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    return -1;
  endfunction

  task automatic utf8_take(input logic [7:0] b, output bit ok);
    logic [7:0] lo;
    logic [7:0] hi;
    ok = 1'b1;
    if (u_pend == 2'd0) begin
      if (b >= 8'h80) begin
        if (b >= 8'hC2 && b <= 8'hDF) begin
          u_pend = 2'd1; u_lim = LIM_ANY;
        end else if (b == 8'hE0) begin
          u_pend = 2'd2; u_lim = LIM_A0;
        end else if (b == 8'hED) begin
          u_pend = 2'd2; u_lim = LIM_9F;
        end else if (b >= 8'hE1 && b <= 8'hEF) begin
          u_pend = 2'd2; u_lim = LIM_ANY;
        end else if (b == 8'hF0) begin
          u_pend = 2'd3; u_lim = LIM_90;
        end else if (b >= 8'hF1 && b <= 8'hF3) begin
          u_pend = 2'd3; u_lim = LIM_ANY;
        end else if (b == 8'hF4) begin
          u_pend = 2'd3; u_lim = LIM_8F;
        end else begin
          ok = 1'b0;
        end
      end
    end else begin
      lo = (u_lim == LIM_A0) ? 8'hA0 : (u_lim == LIM_90) ? 8'h90 : 8'h80;
      hi = (u_lim == LIM_9F) ? 8'h9F : (u_lim == LIM_8F) ? 8'h8F : 8'hBF;
      if (b < lo || b > hi) begin
        ok = 1'b0;
      end else begin
        u_lim = LIM_ANY;
        u_pend = u_pend - 2'd1;
      end
    end
  endtask

  task automatic decode_step(input logic [7:0] b, input logic l, output bit gives,
                             output res_t r);
    int               v;
    bit               have;
    bit               emit;
    bit               ok;
    logic [7:0]       dec;
    upd_pkg::status_e esc_err;
    have = 1'b0;
    emit = 1'b0;
    ok = 1'b0;
    dec = 8'h00;
    esc_err = upd_pkg::STATUS_OK;
    // escape errors freeze the string; a UTF-8 error only stops output
    if (err_st != upd_pkg::STATUS_UNTERM && err_st != upd_pkg::STATUS_BAD_HEX) begin
      v = nibble_of(b);
      case (esc_ph)
        ESC_IDLE: begin
          if (b == PERCENT) begin
            if (l) esc_err = upd_pkg::STATUS_UNTERM;
            else esc_ph = ESC_HI;
          end else begin
            have = 1'b1;
            dec = b;
          end
        end
        ESC_HI: begin
          if (l) esc_err = upd_pkg::STATUS_UNTERM;
          else if (v < 0) esc_err = upd_pkg::STATUS_BAD_HEX;
          else begin
            hi_nib = v[3:0];
            esc_ph = ESC_LO;
          end
        end
        default: begin
          if (v < 0) esc_err = upd_pkg::STATUS_BAD_HEX;
          else begin
            have = 1'b1;
            dec = {hi_nib, v[3:0]};
            esc_ph = ESC_IDLE;
          end
        end
      endcase
      if (esc_err != upd_pkg::STATUS_OK) begin
        err_st = esc_err;
      end else if (have && err_st == upd_pkg::STATUS_OK) begin
        utf8_take(dec, ok);
        if (ok) emit = 1'b1;
        else err_st = upd_pkg::STATUS_BAD_UTF8;
      end
      if (l && err_st == upd_pkg::STATUS_OK && u_pend != 2'd0) begin
        err_st = upd_pkg::STATUS_BAD_UTF8;
      end
    end
    r.data = emit ? dec : 8'h00;
    r.valid = emit;
    r.last = l;
    r.stat = l ? err_st : upd_pkg::STATUS_OK;
    gives = l || emit;
    if (l) begin
      esc_ph = ESC_IDLE;
      hi_nib = 4'h0;
      u_pend = 2'd0;
      u_lim = LIM_ANY;
      err_st = upd_pkg::STATUS_OK;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Drives one word, holds it until taken, then updates the model.
  task automatic send_word(input row_t w);
    bit   gives;
    res_t r;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_byte_i <= w.data;
    in_last_i <= w.last;
    do @(posedge clk_i); while (full);
    decode_step(w.data, w.last, gives, r);
    if (w.typed) begin
      gives = w.gives;
      r = '{w.ebyte, w.evalid, w.last, w.estat};
    end
    if (gives) pending_results.insert(pending_results.size(), r);
    sent_words++;
  endtask

  task automatic add_word(input logic [7:0] v);
    word_q.insert(word_q.size(), v);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  task automatic push_escaped(input logic [7:0] v);
    add_word(PERCENT);
    add_word(hex_char(v[7:4]));
    add_word(hex_char(v[3:0]));
  endtask

  task automatic push_char(input logic [7:0] v);
    if (v == PERCENT || $urandom_range(0, 2) == 0) push_escaped(v);
    else add_word(v);
  endtask

  // One well-formed code point, each byte raw or escaped.
  task automatic push_codepoint();
    logic [7:0] lead;
    case ($urandom_range(1, 4))
      1: push_char(8'($urandom_range(8'h00, 8'h7F)));
      2: begin
        push_char(8'($urandom_range(8'hC2, 8'hDF)));
        push_char(8'($urandom_range(8'h80, 8'hBF)));
      end
      3: begin
        lead = 8'($urandom_range(8'hE0, 8'hEF));
        push_char(lead);
        if (lead == 8'hE0) push_char(8'($urandom_range(8'hA0, 8'hBF)));
        else if (lead == 8'hED) push_char(8'($urandom_range(8'h80, 8'h9F)));
        else push_char(8'($urandom_range(8'h80, 8'hBF)));
        push_char(8'($urandom_range(8'h80, 8'hBF)));
      end
      default: begin
        lead = 8'($urandom_range(8'hF0, 8'hF4));
        push_char(lead);
        if (lead == 8'hF0) push_char(8'($urandom_range(8'h90, 8'hBF)));
        else if (lead == 8'hF4) push_char(8'($urandom_range(8'h80, 8'h8F)));
        else push_char(8'($urandom_range(8'h80, 8'hBF)));
        push_char(8'($urandom_range(8'h80, 8'hBF)));
        push_char(8'($urandom_range(8'h80, 8'hBF)));
      end
    endcase
  endtask

  task automatic push_noise();
    case ($urandom_range(0, 3))
      0: add_word(PERCENT);
      1: add_word(hex_char(4'($urandom_range(0, 15))));
      2: add_word(8'($urandom_range(0, 255)));
      default: push_escaped(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic build_string();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    n = $urandom_range(1, 6);
    word_q.delete();
    if (kind <= 6) begin
      repeat (n) push_codepoint();
    end else if (kind == 7) begin
      // well-formed string with one byte corrupted or the tail cut off
      repeat (n) push_codepoint();
      if ($urandom_range(0, 1) && word_q.size() > 1) word_q.pop_back();
      else word_q[$urandom_range(0, word_q.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (kind == 8) begin
      repeat (3 * n) push_noise();
    end else begin
      // bad UTF-8 first, so a later escape error must take over
      case ($urandom_range(0, 3))
        0: push_char(8'hC0 | 8'($urandom_range(0, 1)));
        1: push_char(8'($urandom_range(8'hF5, 8'hFF)));
        2: push_char(8'($urandom_range(8'h80, 8'hBF)));
        default: begin
          push_char(8'hE0);
          push_char(8'($urandom_range(8'h80, 8'h9F)));
        end
      endcase
      repeat (n) push_codepoint();
      repeat (n) push_noise();
    end
  endtask

  // Result side: check every taken word, then pick pop for the next cycle.
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && pop && !empty) begin
      got = '{out_byte_o, out_byte_valid_o, out_last_o, upd_pkg::status_e'(status_o)};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h valid %0b last %0b",
                                  got.data, got.valid, got.last));
      end else begin
        want = pending_results.pop_front();
        if (got.data !== want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", got.data, want.data));
        if (got.valid !== want.valid)
          report_mismatch($sformatf("out_byte_valid %0b, want %0b", got.valid, want.valid));
        if (got.last !== want.last)
          report_mismatch($sformatf("out_last %0b, want %0b", got.last, want.last));
        if (got.stat !== want.stat)
          report_mismatch($sformatf("status %0d, want %0d", got.stat, want.stat));
      end
    end
    pop <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    row_t w;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_pct = 37;
    rx_idle_pct = 50;
    foreach (DIR_ROWS[i]) send_word(DIR_ROWS[i]);
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        tx_idle_pct = 50;
        rx_idle_pct = 37;
      end else if (ph == 2) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      while (sent_words < (ph + 1) * WORD_TARGET / 3) begin
        build_string();
        foreach (word_q[i]) begin
          w = '0;
          w.data = word_q[i];
          w.last = (i == word_q.size() - 1);
          send_word(w);
        end
      end
    end
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/upd_pkg.sv
rtl/core/upd_front.sv
rtl/core/upd_queue.sv
rtl/core/upd_back.sv
rtl/core/uri_percent_decoder_unit.sv
rtl/core/upd_checker.sv
sim/tb.sv
